// ===== rtl/afa_pkg.sv =====
// shared types, constants and codes of the frame allocator
`timescale 1ns / 1ps
`default_nettype none

package afa_pkg;

   localparam int DEF_MAX_AREAS   = 32;
   localparam int DEF_FRAME_SHIFT = 12;
   localparam int ADDR_W          = 32;
   localparam int CSR_W           = 20;
   localparam int CSR_INDEX_W     = 2;
   localparam int FRAME_INDEX_W   = 20;
   localparam int STATUS_W        = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED    = 2'd0,
      STATUS_NO_MEMORY  = 2'd1,
      STATUS_REGISTERED = 2'd2,
      STATUS_TABLE_FULL = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL_FIRST   = 2'd0,
      CSR_KERNEL_LAST    = 2'd1,
      CSR_BOOTINFO_FIRST = 2'd2,
      CSR_BOOTINFO_LAST  = 2'd3
   } csr_index_type;

   // operands of the shared compare unit
   typedef struct packed {
      logic [ADDR_W-1:0] x;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic              use_last;
      logic [ADDR_W-1:0] area_start;
      logic [ADDR_W-1:0] area_size;
   } cmp_req_type;

   typedef struct packed {
      logic ge;
      logic le;
   } cmp_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/afa_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module afa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/afa_cmp.sv =====
// shared compare unit: range test, optionally against the last frame of an area
`timescale 1ns / 1ps
`default_nettype none

module afa_cmp
   import afa_pkg::*;
#(
   parameter int FRAME_SHIFT = DEF_FRAME_SHIFT
) (
   input  wire cmp_req_type req,
   output cmp_rsp_type      rsp
);

   logic [ADDR_W-1:0] last_addr;
   logic [ADDR_W-1:0] last_frame;
   logic [ADDR_W-1:0] hi;

   always_comb begin
      // 32-bit wrap, a zero size lands just below the area start
      last_addr  = req.area_start + req.area_size - ADDR_W'(1);
      last_frame = last_addr >> FRAME_SHIFT;
      hi         = req.use_last ? last_frame : req.hi;
      rsp.ge     = (req.x >= req.lo);
      rsp.le     = (req.x <= hi);
   end

endmodule

`default_nettype wire

// ===== rtl/area_frame_allocator_core.sv =====
// top level of the frame allocator: sequencer, area table and config registers
//
// Usage: an item is taken when start is high and busy is low. req_cmd 0
// registers the area (req_area_start, req_area_size), req_cmd 1 asks for
// one frame. Each item gives exactly one result: rsp_valid is high for one
// cycle with rsp_status and rsp_frame_index; the receiver cannot stall it.
// Config registers are written through csr_we / csr_index / csr_wdata
// while the block is idle.
//
// Steps from the accepting edge to the result:
//   registration, table full: answered in the cycle after it is taken
//   first registration: it scans the table to pick an area
//   allocation: a grant passes END, KERN and BOOT; out of memory with no area
//     is answered in END; a kernel or boot-info skip goes back to END, and
//     each switch to a new area scans the whole table before END.
// The sequencer visits the table entries one by one through the single
// read port of the area ram and the one shared compare unit. The next
// item can be taken in the cycle that shows the result.
// Reset clears the area count, the free pointer, the current area and the
// config registers; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module area_frame_allocator_core
   import afa_pkg::*;
#(
   parameter int MAX_AREAS   = DEF_MAX_AREAS,
   parameter int FRAME_SHIFT = DEF_FRAME_SHIFT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_cmd,
   input  wire logic [ADDR_W-1:0]        req_area_start,
   input  wire logic [ADDR_W-1:0]        req_area_size,
   output logic                          rsp_valid,
   output logic      [STATUS_W-1:0]      rsp_status,
   output logic      [FRAME_INDEX_W-1:0] rsp_frame_index,
   input  wire logic                     csr_we,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_W-1:0]         csr_wdata
);

   localparam int FW      = ADDR_W - FRAME_SHIFT;
   localparam int CMP_W   = ((FW > CSR_W) ? FW : CSR_W) + 1;
   localparam int CNT_W   = $clog2(MAX_AREAS);
   localparam int BOUND   = 4 * (MAX_AREAS + 4);
   localparam int GUARD_W = $clog2(BOUND + 1);
   localparam int ENT_W   = 2 * ADDR_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_END,
      ST_KERN,
      ST_BOOT,
      ST_SCAN_RD,
      ST_SCAN_LAST,
      ST_SCAN_START,
      ST_SCAN_FIX
   } state_type;

   state_type                state_ff, state_in;
   logic                     cmd_ff, cmd_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CMP_W-1:0]         next_free_ff, next_free_in;
   logic                     cur_valid_ff, cur_valid_in;
   logic [ADDR_W-1:0]        cur_start_ff, cur_start_in;
   logic [ADDR_W-1:0]        cur_size_ff, cur_size_in;
   logic [ADDR_W-1:0]        ent_start_ff, ent_start_in;
   logic [ADDR_W-1:0]        ent_size_ff, ent_size_in;
   logic                     keep_ff, keep_in;
   logic [GUARD_W-1:0]       guard_ff, guard_in;
   logic [CSR_W-1:0]         kernel_first_ff, kernel_first_in;
   logic [CSR_W-1:0]         kernel_last_ff, kernel_last_in;
   logic [CSR_W-1:0]         boot_first_ff, boot_first_in;
   logic [CSR_W-1:0]         boot_last_ff, boot_last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [FRAME_INDEX_W-1:0] rsp_frame_ff, rsp_frame_in;

   logic                     ram_we;
   logic [ENT_W-1:0]         ram_wdata;
   logic [ENT_W-1:0]         ram_rdata;
   cmp_req_type              cmp_req;
   cmp_rsp_type              cmp_rsp;

   logic [ADDR_W-1:0]        nf_ext;
   logic [CMP_W-1:0]         cur_base_frame;

   afa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_AREAS)
   ) u_area_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   afa_cmp #(
      .FRAME_SHIFT (FRAME_SHIFT)
   ) u_cmp (
      .req (cmp_req),
      .rsp (cmp_rsp)
   );

   assign nf_ext         = {{(ADDR_W-CMP_W){1'b0}}, next_free_ff};
   assign cur_base_frame = CMP_W'(cur_start_ff >> FRAME_SHIFT);
   assign ram_wdata      = {req_area_start, req_area_size};

   // operand selection for the shared compare unit
   always_comb begin
      cmp_req            = '0;
      cmp_req.x          = nf_ext;
      cmp_req.area_start = cur_start_ff;
      cmp_req.area_size  = cur_size_ff;
      case (state_ff)
         ST_END: begin
            cmp_req.use_last = 1'b1;
         end
         ST_KERN: begin
            cmp_req.lo = ADDR_W'(kernel_first_ff);
            cmp_req.hi = ADDR_W'(kernel_last_ff);
         end
         ST_BOOT: begin
            cmp_req.lo = ADDR_W'(boot_first_ff);
            cmp_req.hi = ADDR_W'(boot_last_ff);
         end
         ST_SCAN_LAST: begin
            cmp_req.use_last   = 1'b1;
            cmp_req.area_start = ram_rdata[ENT_W-1:ADDR_W];
            cmp_req.area_size  = ram_rdata[ADDR_W-1:0];
         end
         ST_SCAN_START: begin
            cmp_req.x  = ent_start_ff;
            cmp_req.lo = cur_start_ff;
         end
         ST_SCAN_FIX: begin
            cmp_req.lo = {{(ADDR_W-CMP_W){1'b0}}, cur_base_frame};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      next_free_in    = next_free_ff;
      cur_valid_in    = cur_valid_ff;
      cur_start_in    = cur_start_ff;
      cur_size_in     = cur_size_ff;
      ent_start_in    = ent_start_ff;
      ent_size_in     = ent_size_ff;
      keep_in         = keep_ff;
      guard_in        = guard_ff;
      kernel_first_in = kernel_first_ff;
      kernel_last_in  = kernel_last_ff;
      boot_first_in   = boot_first_ff;
      boot_last_in    = boot_last_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_frame_in    = rsp_frame_ff;
      ram_we          = 1'b0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_KERNEL_FIRST:   kernel_first_in = csr_wdata;
            CSR_KERNEL_LAST:    kernel_last_in  = csr_wdata;
            CSR_BOOTINFO_FIRST: boot_first_in   = csr_wdata;
            CSR_BOOTINFO_LAST:  boot_last_in    = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               guard_in = '0;
               if (req_cmd) begin
                  state_in = ST_END;
               end else if (count_ff >= CNT_W'(MAX_AREAS - 1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_TABLE_FULL;
                  rsp_frame_in  = '0;
               end else begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (count_ff == '0) begin
                     // first area becomes the current one
                     cur_valid_in = 1'b0;
                     idx_in       = '0;
                     state_in     = ST_SCAN_RD;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_REGISTERED;
                     rsp_frame_in  = '0;
                  end
               end
            end
         end
         ST_END: begin
            if (guard_ff == GUARD_W'(BOUND) || !cur_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_MEMORY;
               rsp_frame_in  = '0;
               state_in      = ST_IDLE;
            end else if (!cmp_rsp.le) begin
               // current area used up
               cur_valid_in = 1'b0;
               idx_in       = '0;
               state_in     = ST_SCAN_RD;
            end else begin
               state_in = ST_KERN;
            end
         end
         ST_KERN: begin
            if (cmp_rsp.ge && cmp_rsp.le) begin
               next_free_in = CMP_W'(kernel_last_ff) + CMP_W'(1);
               guard_in     = guard_ff + GUARD_W'(1);
               state_in     = ST_END;
            end else begin
               state_in = ST_BOOT;
            end
         end
         ST_BOOT: begin
            if (cmp_rsp.ge && cmp_rsp.le) begin
               next_free_in = CMP_W'(boot_last_ff) + CMP_W'(1);
               guard_in     = guard_ff + GUARD_W'(1);
               state_in     = ST_END;
            end else begin
               next_free_in  = next_free_ff + CMP_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_GRANTED;
               rsp_frame_in  = next_free_ff[FRAME_INDEX_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_LAST;
         end
         ST_SCAN_LAST: begin
            // entry whose last frame lies below the free pointer is skipped
            ent_start_in = ram_rdata[ENT_W-1:ADDR_W];
            ent_size_in  = ram_rdata[ADDR_W-1:0];
            keep_in      = cmp_rsp.le;
            idx_in       = idx_ff + CNT_W'(1);
            state_in     = ST_SCAN_START;
         end
         ST_SCAN_START: begin
            if (keep_ff && (!cur_valid_ff || !cmp_rsp.ge)) begin
               cur_valid_in = 1'b1;
               cur_start_in = ent_start_ff;
               cur_size_in  = ent_size_ff;
            end
            state_in = (idx_ff == count_ff) ? ST_SCAN_FIX : ST_SCAN_LAST;
         end
         ST_SCAN_FIX: begin
            if (cur_valid_ff && !cmp_rsp.ge) begin
               next_free_in = cur_base_frame;
            end
            if (cmd_ff) begin
               guard_in = guard_ff + GUARD_W'(1);
               state_in = ST_END;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_REGISTERED;
               rsp_frame_in  = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         next_free_ff    <= '0;
         cur_valid_ff    <= 1'b0;
         cur_start_ff    <= '0;
         cur_size_ff     <= '0;
         guard_ff        <= '0;
         kernel_first_ff <= '0;
         kernel_last_ff  <= '0;
         boot_first_ff   <= '0;
         boot_last_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         next_free_ff    <= next_free_in;
         cur_valid_ff    <= cur_valid_in;
         cur_start_ff    <= cur_start_in;
         cur_size_ff     <= cur_size_in;
         guard_ff        <= guard_in;
         kernel_first_ff <= kernel_first_in;
         kernel_last_ff  <= kernel_last_in;
         boot_first_ff   <= boot_first_in;
         boot_last_ff    <= boot_last_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      ent_start_ff  <= ent_start_in;
      ent_size_ff   <= ent_size_in;
      keep_ff       <= keep_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame_index = rsp_frame_ff;

endmodule

`default_nettype wire

// ===== rtl/afa_checker.sv =====
// port-level checks of the frame allocator and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module afa_checker
   import afa_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     rsp_valid,
   input wire logic [STATUS_W-1:0]      rsp_status,
   input wire logic [FRAME_INDEX_W-1:0] rsp_frame_index
);

   // a result only ever appears once the block is back to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // an accepted item either keeps the block busy or answers at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither in work nor answered");

   // no result without an item in work or just taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without an item");

   // frame index carries zero unless a frame is granted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_GRANTED) |-> (rsp_frame_index == '0))
      else $error("frame index set on a refused item");

endmodule

bind area_frame_allocator_core afa_checker u_afa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_frame_index (rsp_frame_index)
);

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the area frame allocator core
`timescale 1ns / 1ps

module testbench;
   import afa_pkg::*;

   localparam int        AREA_SLOTS   = DEF_MAX_AREAS;
   localparam int        FSHIFT       = DEF_FRAME_SHIFT;
   localparam int        SEARCH_LIMIT = 4 * (AREA_SLOTS + 4);
   localparam int        STALL_LIMIT  = 100000;
   localparam int        PHASES       = 8;
   localparam int        PHASE_ITEMS  = 55;
   localparam logic      CMD_REGISTER = 1'b0;
   localparam logic      CMD_ALLOCATE = 1'b1;
   localparam logic [19:0] FRAME_TOP  = 20'hFFFFF;

   typedef struct {
      logic        cmd;
      logic [31:0] base;
      logic [31:0] len;
   } alloc_req_type;

   typedef struct {
      status_type  status;
      logic [19:0] frame;
   } alloc_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_cmd = 1'b0;
   logic [ADDR_W-1:0]        req_area_start = '0;
   logic [ADDR_W-1:0]        req_area_size = '0;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic [FRAME_INDEX_W-1:0] rsp_frame_index;
   logic                     csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]         csr_wdata = '0;

   area_frame_allocator_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_area_start  (req_area_start),
      .req_area_size   (req_area_size),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_frame_index (rsp_frame_index),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // allocator shadow state
   logic [19:0] kern_first, kern_last, boot_first, boot_last;
   logic [31:0] area_base_tbl [AREA_SLOTS];
   logic [31:0] area_len_tbl [AREA_SLOTS];
   int unsigned areas_held;
   logic [31:0] free_frame;
   bit          have_area;
   logic [31:0] cur_base, cur_len;

   alloc_req_type pending_items[$];
   alloc_rsp_type results_due[$];
   bit         steady_send;
   int         mismatches, items_taken, stall_cycles;
   int         n_granted, n_no_memory, n_registered, n_table_full;

   // stimulus planning
   logic [31:0] plan_frontier;
   int          plan_credit;
   int          plan_regs;

   function automatic logic [31:0] area_last_frame(input logic [31:0] base, input logic [31:0] len);
      logic [31:0] last_addr;
      last_addr = base + len - 32'd1;
      return last_addr >> FSHIFT;
   endfunction

   // lowest-start area whose last frame is not behind the free pointer
   task automatic choose_area();
      logic [31:0] sf;
      have_area = 1'b0;
      for (int i = 0; i < areas_held; i++) begin
         if (area_last_frame(area_base_tbl[i], area_len_tbl[i]) >= free_frame) begin
            if (!have_area || area_base_tbl[i] < cur_base) begin
               have_area = 1'b1;
               cur_base  = area_base_tbl[i];
               cur_len   = area_len_tbl[i];
            end
         end
      end
      if (have_area) begin
         sf = cur_base >> FSHIFT;
         if (free_frame < sf) free_frame = sf;
      end
   endtask

   task automatic predict_item(input logic cmd, input logic [31:0] base, input logic [31:0] len,
                               output status_type st, output logic [19:0] fr);
      logic [31:0] f;
      bit          done;
      st = STATUS_NO_MEMORY;
      fr = '0;
      if (cmd == CMD_REGISTER) begin
         if (areas_held + 1 >= AREA_SLOTS) begin
            st = STATUS_TABLE_FULL;
         end else begin
            area_base_tbl[areas_held] = base;
            area_len_tbl[areas_held]  = len;
            areas_held++;
            if (areas_held == 1) choose_area();
            st = STATUS_REGISTERED;
         end
      end else begin
         done = 1'b0;
         for (int n = 0; n < SEARCH_LIMIT && !done; n++) begin
            if (!have_area) begin
               done = 1'b1;
            end else begin
               f = free_frame;
               if (f > area_last_frame(cur_base, cur_len)) begin
                  choose_area();
               end else if (f >= kern_first && f <= kern_last) begin
                  free_frame = {12'd0, kern_last} + 32'd1;
               end else if (f >= boot_first && f <= boot_last) begin
                  free_frame = {12'd0, boot_last} + 32'd1;
               end else begin
                  free_frame = f + 32'd1;
                  st   = STATUS_GRANTED;
                  fr   = f[19:0];
                  done = 1'b1;
               end
            end
         end
      end
   endtask

   // driver: hold start until the item is taken
   always @(posedge clock) begin : drive
      alloc_req_type nxt;
      status_type st;
      logic [19:0] fr;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_item(req_cmd, req_area_start, req_area_size, st, fr);
            results_due.push_back('{status: st, frame: fr});
            items_taken++;
         end
         if (!start || !busy) begin
            if (pending_items.size() != 0 && (steady_send || $urandom_range(99, 0) >= 33)) begin
               nxt = pending_items.pop_front();
               start          <= 1'b1;
               req_cmd        <= nxt.cmd;
               req_area_start <= nxt.base;
               req_area_size  <= nxt.len;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      alloc_rsp_type want;
      if (!reset && rsp_valid) begin
         case (status_type'(rsp_status))
            STATUS_GRANTED:    n_granted++;
            STATUS_NO_MEMORY:  n_no_memory++;
            STATUS_REGISTERED: n_registered++;
            default:           n_table_full++;
         endcase
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no item outstanding: status %0d frame %h",
                        $time, rsp_status, rsp_frame_index);
         end else begin
            want = results_due.pop_front();
            if (rsp_status !== want.status || rsp_frame_index !== want.frame) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch: status exp %s got %0d, frame exp %h got %h",
                           $time, want.status.name(), rsp_status, want.frame, rsp_frame_index);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic queue_item(input logic cmd, input logic [31:0] base, input logic [31:0] len);
      pending_items.push_back('{cmd: cmd, base: base, len: len});
      if (cmd == CMD_REGISTER && plan_regs < AREA_SLOTS - 1) plan_regs++;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [19:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_KERNEL_FIRST:   kern_first = val;
         CSR_KERNEL_LAST:    kern_last  = val;
         CSR_BOOTINFO_FIRST: boot_first = val;
         default:            boot_last  = val;
      endcase
   endtask

   task automatic program_skip(input logic [19:0] kf, input logic [19:0] kl,
                               input logic [19:0] bf, input logic [19:0] bl);
      csr_write(CSR_KERNEL_FIRST, kf);
      csr_write(CSR_KERNEL_LAST, kl);
      csr_write(CSR_BOOTINFO_FIRST, bf);
      csr_write(CSR_BOOTINFO_LAST, bl);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // sender pauses until every outstanding item has answered
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || start || results_due.size() != 0);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   // an area just beyond the planned frontier, often not page aligned
   task automatic plan_ordered_area();
      logic [31:0] sframe, base, len, lastf;
      int          nfr, off;
      sframe = plan_frontier + $urandom_range(3, 0);
      nfr    = $urandom_range(40, 1);
      off    = ($urandom_range(3, 0) == 0) ? $urandom_range(4095, 1) : 0;
      base   = (sframe << FSHIFT) | off;
      len    = nfr * 4096 - $urandom_range(4095, 0);
      lastf  = area_last_frame(base, len);
      plan_credit  += lastf - sframe + 1;
      plan_frontier = lastf + 1;
      queue_item(CMD_REGISTER, base, len);
   endtask

   task automatic pick_range(output logic [19:0] lo, output logic [19:0] hi);
      case ($urandom_range(2, 0))
         0: begin
            lo = 20'(plan_frontier + $urandom_range(6, 0));
            hi = 20'(lo + $urandom_range(3, 0));
            plan_credit -= 4;
         end
         1: begin
            // inverted, skips nothing
            lo = 20'(plan_frontier + $urandom_range(8, 2));
            hi = 20'(lo - $urandom_range(2, 1));
         end
         default: begin
            // already behind the free pointer
            lo = 20'($urandom_range(8, 0));
            hi = 20'(lo + $urandom_range(4, 0));
         end
      endcase
   endtask

   initial begin : stimulus
      logic [19:0] kf, kl, bf, bl;
      int          pick;
      kern_first = '0; kern_last = '0; boot_first = '0; boot_last = '0;
      areas_held = 0; free_frame = '0; have_area = 1'b0; cur_base = '0; cur_len = '0;
      steady_send = 1'b0; mismatches = 0; items_taken = 0; stall_cycles = 0;
      n_granted = 0; n_no_memory = 0; n_registered = 0; n_table_full = 0;
      plan_regs = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // inverted kernel range at the extremes, boot info on frame zero
      program_skip(FRAME_TOP, 20'd0, 20'd0, 20'd0);
      queue_item(CMD_ALLOCATE, 32'h0, 32'h0);            // no area yet
      queue_item(CMD_REGISTER, 32'h0000_0000, 32'h0000_4000);
      queue_item(CMD_ALLOCATE, 32'h0, 32'h0);            // frame zero skipped
      queue_item(CMD_ALLOCATE, 32'h0, 32'h0);
      queue_item(CMD_ALLOCATE, 32'h0, 32'h0);
      queue_item(CMD_REGISTER, 32'h0000_5000, 32'h0);    // zero size, aligned: empty
      queue_item(CMD_REGISTER, 32'h0000_7800, 32'h0);    // zero size, unaligned: one frame
      queue_item(CMD_REGISTER, 32'h0000_9000, 32'h1);
      queue_item(CMD_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(CMD_REGISTER, 32'hFFFF_E000, 32'h0000_1000);
      queue_item(CMD_ALLOCATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // switches twice
      queue_item(CMD_ALLOCATE, 32'h0, 32'h0);
      wait_idle();

      // overlapping kernel and boot info ranges inside the next area
      program_skip(20'd18, 20'd19, 20'd19, 20'd21);
      queue_item(CMD_REGISTER, 32'h0001_0000, 32'h0000_8000);
      repeat (5) queue_item(CMD_ALLOCATE, 32'h0, 32'h0);
      wait_idle();
      plan_frontier = 32'd24;
      plan_credit   = 0;

      for (int ph = 0; ph < PHASES; ph++) begin
         pick_range(kf, kl);
         pick_range(bf, bl);
         program_skip(kf, kl, bf, bl);
         steady_send = (ph == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99, 0);
            if (plan_credit < 6 && plan_regs < AREA_SLOTS - 1) begin
               plan_ordered_area();
            end else if (pick < 4) begin
               queue_item(CMD_REGISTER, $urandom(), $urandom());
            end else if (pick < 6) begin
               queue_item(CMD_REGISTER, plan_frontier << FSHIFT, 32'h0);
               plan_frontier++;
            end else begin
               queue_item(CMD_ALLOCATE, $urandom(), $urandom());
               plan_credit--;
            end
         end
         wait_idle();
      end
      steady_send = 1'b0;

      // boot info reaching the top frame: the free pointer runs past the frame space
      program_skip(FRAME_TOP, FRAME_TOP, 20'h80000, FRAME_TOP);
      repeat (10) queue_item(CMD_ALLOCATE, 32'h0, 32'h0);
      while (plan_regs < AREA_SLOTS - 1) plan_ordered_area();
      repeat (3) queue_item(CMD_REGISTER, $urandom(), $urandom());   // table full
      repeat (20) queue_item(CMD_ALLOCATE, 32'h0, 32'h0);
      wait_idle();
      repeat (20) @(posedge clock);

      $display("%0d items: %0d frames granted, %0d out of memory, %0d areas registered, %0d refused",
               items_taken, n_granted, n_no_memory, n_registered, n_table_full);
      $display("skip ranges changed over %0d phases, %0d mismatches", PHASES + 3, mismatches);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/afa_pkg.sv
rtl/afa_ram.sv
rtl/afa_cmp.sv
rtl/area_frame_allocator_core.sv
rtl/afa_checker.sv
test/testbench.sv
